FILE: hw/rtl/ocd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_pkg
// shared types and constants for the optics neighbor / core distance block
// ----------------------------------------------------------------------------
package ocd_pkg;

    localparam int IDX_W   = 10;
    localparam int DIST_W  = 32;
    localparam int COUNT_W = 11;
    localparam int MINP_W  = 4;
    localparam int CFG_IDX_W = 2;

    // default depth of the sorted distance list
    localparam int RANK_DEPTH = 16;

    localparam logic [DIST_W-1:0]  DIST_EMPTY    = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
    localparam logic [DIST_W-1:0]  EPS_RESET     = 32'h0001_0000;
    localparam logic [MINP_W-1:0]  MIN_PTS_RESET = 4'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EPS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PTS = 2'd1;

    typedef struct packed {
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  column_index;
        logic [DIST_W-1:0] pair_distance;
        logic              last_in_row;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]   neighbor_index;
        logic               is_neighbor;
        logic               row_done;
        logic [COUNT_W-1:0] neighbor_total;
        logic               core_valid;
        logic [DIST_W-1:0]  core_dist;
    } t_out_word;

    typedef struct packed {
        logic [DIST_W-1:0] eps_threshold;
        logic [MINP_W-1:0] min_points;
    } t_cfg;

endpackage

FILE: hw/rtl/ocd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_cfg_regs
// configuration register file: eps threshold and min points
// ----------------------------------------------------------------------------
module ocd_cfg_regs
    import ocd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0]    i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eps_threshold <= EPS_RESET;
            r_cfg.min_points    <= MIN_PTS_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EPS:     r_cfg.eps_threshold <= i_cfg_data;
                CFG_MIN_PTS: r_cfg.min_points    <= i_cfg_data[MINP_W-1:0];
                default:     ;
            endcase
        end
    end

endmodule

FILE: hw/rtl/ocd_rank_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ocd_rank_list
// sorted list of the smallest row distances, parallel compare and shift
// ----------------------------------------------------------------------------
module ocd_rank_list
    import ocd_pkg::*;
#(
    parameter int MAX_RANK = RANK_DEPTH
)(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_update,
    input  logic              i_clear,
    input  logic [DIST_W-1:0] i_dist,
    input  logic [MINP_W-1:0] i_rank,
    output logic [DIST_W-1:0] o_rank_dist
);

    localparam int IW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    logic [DIST_W-1:0] r_list [MAX_RANK];
    logic [DIST_W-1:0] n_list [MAX_RANK];
    logic [MAX_RANK-1:0] le;
    logic [IW-1:0] sel;
    logic sorted;

    // le is a prefix of ones since the list stays ascending
    always_comb begin
        for (int i = 0; i < MAX_RANK; i++) begin
            le[i] = (r_list[i] <= i_dist);
        end
        for (int i = 0; i < MAX_RANK; i++) begin
            if (le[i]) begin
                n_list[i] = r_list[i];
            end else if (i == 0) begin
                n_list[i] = i_dist;
            end else if (le[i-1]) begin
                n_list[i] = i_dist;
            end else begin
                n_list[i] = r_list[i-1];
            end
        end
    end

    // rank past the end of storage picks the last slot
    always_comb begin
        if (int'(i_rank) >= MAX_RANK) begin
            sel = IW'(MAX_RANK - 1);
        end else begin
            sel = IW'(i_rank);
        end
    end

    assign o_rank_dist = n_list[sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_RANK; i++) begin
                r_list[i] <= DIST_EMPTY;
            end
        end else if (i_update) begin
            for (int i = 0; i < MAX_RANK; i++) begin
                r_list[i] <= i_clear ? DIST_EMPTY : n_list[i];
            end
        end
    end

    always_comb begin
        sorted = 1'b1;
        for (int i = 0; i < MAX_RANK - 1; i++) begin
            if (r_list[i] > r_list[i+1]) begin
                sorted = 1'b0;
            end
        end
    end

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n) sorted)
        else $error("distance list out of order");

    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_update && i_clear |=> r_list[MAX_RANK-1] == DIST_EMPTY && r_list[0] == DIST_EMPTY)
        else $error("distance list not cleared after row");

    a_pick_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_update && !le[0] |-> n_list[0] == i_dist)
        else $error("new minimum not placed at head");

endmodule

FILE: hw/rtl/optics_neighbor_core_distance_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// optics_neighbor_core_distance_top
// optics neighborhood flag and core distance over one streamed matrix row
//
// distances of one row arrive one word per cycle; each word is flagged as a
// neighbor when its column differs from its row and its distance is at most
// eps, a saturating neighbor count runs over the row, and the smallest
// MAX_RANK distances are kept in a sorted list. the word marked last in row
// returns the count and, when the count reaches min points, the
// (min points + 1)-th smallest distance of the row, after which the row
// state clears. throughput is one word per cycle while the output does not
// stall; words pass the input and then the result register. per cycle the
// work is the MAX_RANK-wide sorted list compare and shift, then rank select.
// ----------------------------------------------------------------------------
module optics_neighbor_core_distance_top
    import ocd_pkg::*;
#(
    parameter int MAX_RANK = RANK_DEPTH
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input word channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_word             i_in_word,
    // result word channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_word            o_out_word,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIST_W-1:0]    i_cfg_data
);

    t_cfg cfg;

    // input register and result register
    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic              move;      // result register can take a new word
    logic              fire;      // word in the input register is processed
    logic              nb;
    logic              core_ok;
    logic [DIST_W-1:0] rank_dist;
    t_out_word         n_out;

    ocd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // result register frees up when empty or when its word is taken
    assign move = !r_out_valid || !i_out_stall;
    assign fire = r_in_valid && move;

    // input side only waits while a word is held and cannot move on
    assign o_in_stall = r_in_valid && !move;

    // neighbor test against this word's own row index
    assign nb = (r_in.row_index != r_in.column_index)
              && (r_in.pair_distance <= cfg.eps_threshold);

    // saturating row neighbor count, this word included
    always_comb begin
        if (nb && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    ocd_rank_list #(
        .MAX_RANK (MAX_RANK)
    ) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (fire),
        .i_clear     (r_in.last_in_row),
        .i_dist      (r_in.pair_distance),
        .i_rank      (cfg.min_points),
        .o_rank_dist (rank_dist)
    );

    assign core_ok = n_count >= COUNT_W'(cfg.min_points);

    // row summary fields are only filled on the last word of a row
    always_comb begin
        n_out.neighbor_index = r_in.column_index;
        n_out.is_neighbor    = nb;
        n_out.row_done       = r_in.last_in_row;
        n_out.neighbor_total = '0;
        n_out.core_valid     = 1'b0;
        n_out.core_dist      = '0;
        if (r_in.last_in_row) begin
            n_out.neighbor_total = n_count;
            n_out.core_valid     = core_ok;
            n_out.core_dist      = core_ok ? rank_dist : '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_count <= r_in.last_in_row ? '0 : n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_word;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_mid_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.row_done |->
            o_out_word.neighbor_total == '0 && !o_out_word.core_valid
            && o_out_word.core_dist == '0)
        else $error("row summary present on a word that is not last in row");

    a_last_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.row_done && o_out_word.is_neighbor |->
            o_out_word.neighbor_total != '0)
        else $error("neighbor on last word missing from row total");

    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.last_in_row |=> r_count == '0)
        else $error("neighbor count not cleared after row");

endmodule
